@@ src/rfsu_pkg.sv @@
// shared types and constants for the real fft split untwiddle core
package rfsu_pkg;

    // sizes of the bin store and the data path
    localparam int MAX_HALF_LENGTH   = 1024;
    localparam int SAMPLE_WIDTH      = 32;
    localparam int TWIDDLE_WIDTH     = 18;
    localparam int TWIDDLE_FRAC_BITS = 16;
    localparam int INDEX_WIDTH       = 11;
    localparam int STORE_DEPTH       = MAX_HALF_LENGTH + 1;
    localparam int CFG_INDEX_WIDTH   = 2;
    localparam int CFG_DATA_WIDTH    = 11;

    // command codes
    localparam logic CMD_WRITE   = 1'b0;
    localparam logic CMD_REQUEST = 1'b1;

    // configuration register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DIRECTION   = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_HALF_LENGTH = 2'd1;

    // direction codes
    localparam logic DIR_FORWARD = 1'b0;
    localparam logic DIR_INVERSE = 1'b1;

    // request sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_HALF,
        S_MULT,
        S_SUM
    } t_state;

    // kind of request, fixed at accept
    typedef enum logic [2:0] {
        OP_GENERAL,
        OP_FWD_DC,
        OP_FWD_NYQ,
        OP_INV_DC,
        OP_ERROR
    } t_op;

endpackage

@@ src/real_fft_split_untwiddle_core.sv @@
// Real FFT split untwiddle core: bin store, read-modify pipeline and result port.
// A write word never raises o_busy. Results cannot be held off.
// A request holds o_busy while it runs, and its result strobes on o_done for one cycle
// at the end of its steps: store read, halving, twiddle products, sum and saturation.
// A new request is not taken until the four-step request sequencer has finished the last one.
// Synchronous active-low reset clears the sequencer, o_done and the config registers; the store is not cleared.
module real_fft_split_untwiddle_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    output logic                                   o_busy,
    input  logic                                   i_command,
    input  logic [rfsu_pkg::INDEX_WIDTH-1:0]       i_index,
    input  logic signed [rfsu_pkg::SAMPLE_WIDTH-1:0]  i_value_re,
    input  logic signed [rfsu_pkg::SAMPLE_WIDTH-1:0]  i_value_im,
    input  logic signed [rfsu_pkg::TWIDDLE_WIDTH-1:0] i_rot_re,
    input  logic signed [rfsu_pkg::TWIDDLE_WIDTH-1:0] i_rot_im,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [rfsu_pkg::CFG_INDEX_WIDTH-1:0]   i_cfg_index,
    input  logic [rfsu_pkg::CFG_DATA_WIDTH-1:0]    i_cfg_data,
    output logic                                   o_done,
    output logic [rfsu_pkg::INDEX_WIDTH-1:0]       o_result_index,
    output logic signed [rfsu_pkg::SAMPLE_WIDTH-1:0]  o_result_re,
    output logic signed [rfsu_pkg::SAMPLE_WIDTH-1:0]  o_result_im,
    output logic                                   o_index_error
);
    import rfsu_pkg::*;

    localparam int PROD_W = SAMPLE_WIDTH + TWIDDLE_WIDTH;
    localparam int MQ_W   = PROD_W - TWIDDLE_FRAC_BITS;
    localparam int ER_W   = SAMPLE_WIDTH + 2;
    localparam int ACC_W  = SAMPLE_WIDTH + 5;
    localparam int WORD_W = 2 * SAMPLE_WIDTH;

    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - ACC_W'(1);

    // saturate a wide sum to the sample width
    function automatic logic signed [SAMPLE_WIDTH-1:0] sat(input logic signed [ACC_W-1:0] x);
        logic signed [SAMPLE_WIDTH-1:0] y;
        if (x > SAT_MAX) begin
            y = SAT_MAX[SAMPLE_WIDTH-1:0];
        end else if (x < SAT_MIN) begin
            y = SAT_MIN[SAMPLE_WIDTH-1:0];
        end else begin
            y = x[SAMPLE_WIDTH-1:0];
        end
        return y;
    endfunction

    // configuration registers
    logic                   r_direction;
    logic [INDEX_WIDTH-1:0] r_half_length;

    // sequencer
    t_state r_state, n_state;

    // bin store, re in the upper half of each word
    logic [WORD_W-1:0] r_mem [STORE_DEPTH];
    logic [WORD_W-1:0] r_rd_a, r_rd_b;

    // request context
    t_op                         r_op;
    logic                        r_dir;
    logic [INDEX_WIDTH-1:0]      r_k;
    logic signed [TWIDDLE_WIDTH-1:0] r_twr, r_twi;

    // halving stage
    logic signed [ER_W-1:0]         r_er, r_ei;
    logic signed [SAMPLE_WIDTH-1:0] r_u, r_v;

    // product stage
    logic signed [PROD_W-1:0] r_m1, r_m2, r_m3, r_m4;

    // accept decode
    logic                   w_accept;
    logic                   w_req;
    logic                   w_wr;
    logic [INDEX_WIDTH-1:0] w_n;
    logic [INDEX_WIDTH-1:0] w_addr_a, w_addr_b;
    t_op                    w_op;

    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_start && !o_busy;
    assign w_req       = w_accept && (i_command == CMD_REQUEST);
    assign w_wr        = w_accept && (i_command == CMD_WRITE)
                         && (i_index <= INDEX_WIDTH'(MAX_HALF_LENGTH));

    // clamp half length to its legal range
    always_comb begin
        if (r_half_length == '0) begin
            w_n = INDEX_WIDTH'(1);
        end else if (r_half_length > INDEX_WIDTH'(MAX_HALF_LENGTH)) begin
            w_n = INDEX_WIDTH'(MAX_HALF_LENGTH);
        end else begin
            w_n = r_half_length;
        end
    end

    // classify the request and pick the store addresses
    always_comb begin
        w_op     = OP_GENERAL;
        w_addr_a = i_index;
        w_addr_b = w_n - i_index;
        if (r_direction == DIR_FORWARD) begin
            if (i_index > w_n) begin
                w_op = OP_ERROR;
            end else if (i_index == '0) begin
                w_op = OP_FWD_DC;
            end else if (i_index == w_n) begin
                // nyquist comes from bin zero
                w_op     = OP_FWD_NYQ;
                w_addr_a = '0;
            end
        end else begin
            if (i_index >= w_n) begin
                w_op = OP_ERROR;
            end else if (i_index == '0) begin
                w_op = OP_INV_DC;
            end
        end
        if (w_op == OP_ERROR) begin
            w_addr_a = '0;
            w_addr_b = '0;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction   <= DIR_FORWARD;
            r_half_length <= INDEX_WIDTH'(MAX_HALF_LENGTH);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_DIRECTION:   r_direction   <= i_cfg_data[0];
                REG_HALF_LENGTH: r_half_length <= i_cfg_data[INDEX_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // bin store: one write port, two read ports with registered data
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[i_index] <= {i_value_re, i_value_im};
        end
        if (w_req) begin
            r_rd_a <= r_mem[w_addr_a];
            r_rd_b <= r_mem[w_addr_b];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_req) n_state = S_HALF;
            S_HALF: n_state = S_MULT;
            S_MULT: n_state = S_SUM;
            S_SUM:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_busy = (r_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // latch request context
    always_ff @(posedge i_clk) begin
        if (w_req) begin
            r_op  <= w_op;
            r_dir <= r_direction;
            r_k   <= i_index;
            r_twr <= i_rot_re;
            r_twi <= i_rot_im;
        end
    end

    // halving stage
    logic signed [SAMPLE_WIDTH-1:0] w_ar, w_ai, w_br, w_bi;
    logic signed [SAMPLE_WIDTH:0]   w_sr, w_di, w_si, w_dr, w_dn, w_aa, w_ad;
    logic signed [ER_W-1:0]         n_er, n_ei;
    logic signed [SAMPLE_WIDTH-1:0] n_u, n_v;

    assign w_ar = r_rd_a[WORD_W-1:SAMPLE_WIDTH];
    assign w_ai = r_rd_a[SAMPLE_WIDTH-1:0];
    assign w_br = r_rd_b[WORD_W-1:SAMPLE_WIDTH];
    assign w_bi = r_rd_b[SAMPLE_WIDTH-1:0];

    always_comb begin
        w_sr = (SAMPLE_WIDTH+1)'(w_ar) + (SAMPLE_WIDTH+1)'(w_br);
        w_di = (SAMPLE_WIDTH+1)'(w_ai) - (SAMPLE_WIDTH+1)'(w_bi);
        w_si = (SAMPLE_WIDTH+1)'(w_ai) + (SAMPLE_WIDTH+1)'(w_bi);
        w_dr = (SAMPLE_WIDTH+1)'(w_ar) - (SAMPLE_WIDTH+1)'(w_br);
        w_dn = (SAMPLE_WIDTH+1)'(w_br) - (SAMPLE_WIDTH+1)'(w_ar);
        w_aa = (SAMPLE_WIDTH+1)'(w_ar) + (SAMPLE_WIDTH+1)'(w_ai);
        w_ad = (SAMPLE_WIDTH+1)'(w_ar) - (SAMPLE_WIDTH+1)'(w_ai);
        n_er = '0;
        n_ei = '0;
        n_u  = '0;
        n_v  = '0;
        case (r_op)
            OP_GENERAL: begin
                n_er = ER_W'($signed(w_sr[SAMPLE_WIDTH:1]));
                n_ei = ER_W'($signed(w_di[SAMPLE_WIDTH:1]));
                n_u  = w_si[SAMPLE_WIDTH:1];
                n_v  = (r_dir == DIR_INVERSE) ? w_dr[SAMPLE_WIDTH:1] : w_dn[SAMPLE_WIDTH:1];
            end
            OP_FWD_DC:  n_er = ER_W'(w_aa);
            OP_FWD_NYQ: n_er = ER_W'(w_ad);
            OP_INV_DC: begin
                n_er = ER_W'($signed(w_sr[SAMPLE_WIDTH:1]));
                n_ei = ER_W'($signed(w_dr[SAMPLE_WIDTH:1]));
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_HALF) begin
            r_er <= n_er;
            r_ei <= n_ei;
            r_u  <= n_u;
            r_v  <= n_v;
        end
    end

    // twiddle products
    always_ff @(posedge i_clk) begin
        if (r_state == S_MULT) begin
            r_m1 <= PROD_W'(r_u) * PROD_W'(r_twr);
            r_m2 <= PROD_W'(r_v) * PROD_W'(r_twi);
            r_m3 <= PROD_W'(r_v) * PROD_W'(r_twr);
            r_m4 <= PROD_W'(r_u) * PROD_W'(r_twi);
        end
    end

    // floor each product, sum and saturate
    logic signed [MQ_W-1:0]  w_q1, w_q2, w_q3, w_q4;
    logic signed [ACC_W-1:0] w_cross, w_rr, w_ri;
    logic                    w_err;

    assign w_q1 = r_m1[PROD_W-1:TWIDDLE_FRAC_BITS];
    assign w_q2 = r_m2[PROD_W-1:TWIDDLE_FRAC_BITS];
    assign w_q3 = r_m3[PROD_W-1:TWIDDLE_FRAC_BITS];
    assign w_q4 = r_m4[PROD_W-1:TWIDDLE_FRAC_BITS];
    assign w_err = (r_op == OP_ERROR);

    always_comb begin
        w_cross = ACC_W'(w_q1) - ACC_W'(w_q2);
        if (r_dir == DIR_INVERSE) begin
            w_rr = ACC_W'(r_er) - w_cross;
        end else begin
            w_rr = ACC_W'(r_er) + w_cross;
        end
        w_ri = ACC_W'(r_ei) + ACC_W'(w_q3) + ACC_W'(w_q4);
    end

    // result register and strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= (r_state == S_SUM);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_SUM) begin
            o_result_index <= r_k;
            o_result_re    <= w_err ? '0 : sat(w_rr);
            o_result_im    <= w_err ? '0 : sat(w_ri);
            o_index_error  <= w_err;
        end
    end

`ifndef SYNTHESIS
    // a result strobe follows exactly the last pipeline step
    a_done_after_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_SUM))
        else $error("result strobe without a finished request");

    // an accepted request occupies the block in the next cycle
    a_req_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_command == CMD_REQUEST) |=> o_busy)
        else $error("request accepted but block not busy");

    // a flagged index gives a zero result
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_index_error) |-> (o_result_re == '0 && o_result_im == '0))
        else $error("index error with nonzero result");

    // the block stays busy for the whole request sequence, then frees itself
    a_busy_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_command == CMD_REQUEST) |=> (o_busy [*3] ##1 !o_busy))
        else $error("request sequence length wrong");
`endif

endmodule

@@ sim/tb_top.sv @@
// self-checking testbench for the real fft split untwiddle core
`timescale 1ns / 1ps

module tb_top;
    import rfsu_pkg::*;

    localparam int CYCLE_LIMIT     = 500000;
    localparam int RESET_CYCLES    = 11;
    localparam int DRAIN_CYCLES    = 8;
    localparam int WORDS_PER_PHASE = 36;
    localparam int RANDOM_PHASES   = 14;
    localparam int TW_ONE          = 1 << TWIDDLE_FRAC_BITS;
    localparam real PI             = 3.14159265358979;

    // register indexes the core does not decode
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_B = 2'd3;

    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    typedef struct {
        logic                             cmd;
        logic [INDEX_WIDTH-1:0]           index;
        logic signed [SAMPLE_WIDTH-1:0]   value_re;
        logic signed [SAMPLE_WIDTH-1:0]   value_im;
        logic signed [TWIDDLE_WIDTH-1:0]  rot_re;
        logic signed [TWIDDLE_WIDTH-1:0]  rot_im;
    } t_bin_word;

    typedef struct {
        logic [INDEX_WIDTH-1:0]           index;
        logic signed [SAMPLE_WIDTH-1:0]   re;
        logic signed [SAMPLE_WIDTH-1:0]   im;
        logic                             error;
    } t_bin_result;

    typedef struct {
        logic [CFG_INDEX_WIDTH-1:0]       index;
        logic [CFG_DATA_WIDTH-1:0]        data;
    } t_reg_word;

    // dut ports
    logic                             i_clk        = 1'b0;
    logic                             i_rst_n      = 1'b0;
    logic                             i_start      = 1'b0;
    logic                             i_command    = CMD_WRITE;
    logic [INDEX_WIDTH-1:0]           i_index      = '0;
    logic signed [SAMPLE_WIDTH-1:0]   i_value_re   = '0;
    logic signed [SAMPLE_WIDTH-1:0]   i_value_im   = '0;
    logic signed [TWIDDLE_WIDTH-1:0]  i_rot_re     = '0;
    logic signed [TWIDDLE_WIDTH-1:0]  i_rot_im     = '0;
    logic                             i_cfg_valid  = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0]       i_cfg_index  = '0;
    logic [CFG_DATA_WIDTH-1:0]        i_cfg_data   = '0;
    logic                             o_busy;
    logic                             o_cfg_ready;
    logic                             o_done;
    logic [INDEX_WIDTH-1:0]           o_result_index;
    logic signed [SAMPLE_WIDTH-1:0]   o_result_re;
    logic signed [SAMPLE_WIDTH-1:0]   o_result_im;
    logic                             o_index_error;

    // predictor copy of the store and the registers
    logic signed [SAMPLE_WIDTH-1:0]   store_re_model [0:STORE_DEPTH-1];
    logic signed [SAMPLE_WIDTH-1:0]   store_im_model [0:STORE_DEPTH-1];
    logic                             model_direction   = DIR_FORWARD;
    logic [CFG_DATA_WIDTH-1:0]        model_half_length = CFG_DATA_WIDTH'(MAX_HALF_LENGTH);

    // stimulus side bookkeeping
    bit                               bin_written [0:STORE_DEPTH-1];
    logic                             gen_direction = DIR_FORWARD;
    int                               gen_n         = MAX_HALF_LENGTH;

    t_bin_word                        pending_words [$];
    t_reg_word                        pending_regs  [$];
    t_bin_result                      expected_bins [$];

    int                               gap_left    = 0;
    bit                               steady_run  = 1'b0;
    int                               reset_count = 0;
    int                               cycle_count = 0;
    int                               fail_count  = 0;

    real_fft_split_untwiddle_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_command      (i_command),
        .i_index        (i_index),
        .i_value_re     (i_value_re),
        .i_value_im     (i_value_im),
        .i_rot_re       (i_rot_re),
        .i_rot_im       (i_rot_im),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_done         (o_done),
        .o_result_index (o_result_index),
        .o_result_re    (o_result_re),
        .o_result_im    (o_result_im),
        .o_index_error  (o_index_error)
    );

    // clock, 2 ns period
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // reset held low for the first cycles only
    always @(posedge i_clk) begin
        if (reset_count < RESET_CYCLES) begin
            reset_count <= reset_count + 1;
            i_rst_n     <= 1'b0;
        end else begin
            i_rst_n <= 1'b1;
        end
    end

    // half length as the core clamps it
    function automatic int effective_n(input logic [CFG_DATA_WIDTH-1:0] h);
        if (h == 0)
            return 1;
        if (h > MAX_HALF_LENGTH)
            return MAX_HALF_LENGTH;
        return int'(h);
    endfunction

    // q1.16 product, floored on its own
    function automatic longint twiddle_product(input longint a, input longint b);
        return (a * b) >>> TWIDDLE_FRAC_BITS;
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] clamp_sample(input longint v);
        if (v > longint'(SAMPLE_MAX))
            return SAMPLE_MAX;
        if (v < longint'(SAMPLE_MIN))
            return SAMPLE_MIN;
        return v[SAMPLE_WIDTH-1:0];
    endfunction

    // update the store on a write word, queue the expected bin on a request
    function automatic void untwiddle_accept(input t_bin_word w);
        t_bin_result r;
        int          k, n, m;
        longint      kr, ki, mr, mi, er, ei, hr, hi, orr, oi, rr, ri, twr, twi;
        k = int'(w.index);
        n = effective_n(model_half_length);
        if (w.cmd == CMD_WRITE) begin
            if (k <= MAX_HALF_LENGTH) begin
                store_re_model[k] = w.value_re;
                store_im_model[k] = w.value_im;
            end
            return;
        end
        rr      = 0;
        ri      = 0;
        r.index = w.index;
        r.error = 1'b0;
        twr     = w.rot_re;
        twi     = w.rot_im;
        m       = n - k;
        if (model_direction == DIR_FORWARD) begin
            if (k > n) begin
                r.error = 1'b1;
            end else if (k == 0 || k == n) begin
                // dc and nyquist come from bin zero alone
                kr = store_re_model[0];
                ki = store_im_model[0];
                rr = (k == 0) ? kr + ki : kr - ki;
            end else begin
                kr  = store_re_model[k];
                ki  = store_im_model[k];
                mr  = store_re_model[m];
                mi  = store_im_model[m];
                er  = (kr + mr) >>> 1;
                ei  = (ki - mi) >>> 1;
                orr = (ki + mi) >>> 1;
                oi  = (mr - kr) >>> 1;
                rr  = er + (twiddle_product(orr, twr) - twiddle_product(oi, twi));
                ri  = ei + (twiddle_product(oi, twr) + twiddle_product(orr, twi));
            end
        end else begin
            if (k >= n) begin
                r.error = 1'b1;
            end else if (k == 0) begin
                kr = store_re_model[0];
                mr = store_re_model[n];
                rr = (kr + mr) >>> 1;
                ri = (kr - mr) >>> 1;
            end else begin
                kr  = store_re_model[k];
                ki  = store_im_model[k];
                mr  = store_re_model[m];
                mi  = store_im_model[m];
                er  = (kr + mr) >>> 1;
                ei  = (ki - mi) >>> 1;
                hr  = (kr - mr) >>> 1;
                hi  = (ki + mi) >>> 1;
                orr = twiddle_product(hr, twr) + twiddle_product(hi, twi);
                oi  = twiddle_product(hi, twr) - twiddle_product(hr, twi);
                rr  = er - oi;
                ri  = ei + orr;
            end
        end
        r.re = r.error ? '0 : clamp_sample(rr);
        r.im = r.error ? '0 : clamp_sample(ri);
        expected_bins.push_back(r);
    endfunction

    // idle length after a word, short mostly, with runs of none
    function automatic int draw_gap();
        int r;
        if ($urandom_range(0, 63) == 0)
            steady_run = !steady_run;
        if (steady_run)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(5, 40);
    endfunction

    // word driver: holds a word until start meets a free core
    always @(posedge i_clk) begin : word_driver
        bit fire;
        fire = i_start && !o_busy;
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            if (fire)
                untwiddle_accept(pending_words.pop_front());
            if (i_start && !fire) begin
                // word still waiting on busy
            end else if (gap_left > 0) begin
                gap_left = gap_left - 1;
                i_start <= 1'b0;
            end else if (pending_words.size() != 0) begin
                i_start    <= 1'b1;
                i_command  <= pending_words[0].cmd;
                i_index    <= pending_words[0].index;
                i_value_re <= pending_words[0].value_re;
                i_value_im <= pending_words[0].value_im;
                i_rot_re   <= pending_words[0].rot_re;
                i_rot_im   <= pending_words[0].rot_im;
                gap_left = draw_gap();
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // register write channel
    always @(posedge i_clk) begin : reg_driver
        t_reg_word w;
        if (!i_rst_n) begin
            i_cfg_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                w = pending_regs.pop_front();
                case (w.index)
                    REG_DIRECTION:   model_direction = w.data[0];
                    REG_HALF_LENGTH: model_half_length = w.data;
                    default: ;
                endcase
            end
            if (pending_regs.size() != 0) begin
                i_cfg_valid <= 1'b1;
                i_cfg_index <= pending_regs[0].index;
                i_cfg_data  <= pending_regs[0].data;
            end else begin
                i_cfg_valid <= 1'b0;
            end
        end
    end

    // result monitor: compare each strobed word with the oldest expected bin
    always @(posedge i_clk) begin : result_check
        t_bin_result want;
        if (i_rst_n && o_done) begin
            if (expected_bins.size() == 0) begin
                $error("result word with nothing expected, index %0d", o_result_index);
                fail_count = fail_count + 1;
            end else begin
                want = expected_bins.pop_front();
                if (o_result_index !== want.index) begin
                    $error("result_index: expected %0d, got %0d", want.index, o_result_index);
                    fail_count = fail_count + 1;
                end
                if (o_result_re !== want.re) begin
                    $error("result_re: expected %0d, got %0d", want.re, o_result_re);
                    fail_count = fail_count + 1;
                end
                if (o_result_im !== want.im) begin
                    $error("result_im: expected %0d, got %0d", want.im, o_result_im);
                    fail_count = fail_count + 1;
                end
                if (o_index_error !== want.error) begin
                    $error("index_error: expected %0b, got %0b", want.error, o_index_error);
                    fail_count = fail_count + 1;
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL real_fft_split_untwiddle_core");
            $finish;
        end
    end

    function automatic logic signed [SAMPLE_WIDTH-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return '0;
            3:       return '1;
            4, 5:    return SAMPLE_WIDTH'(int'($urandom_range(0, 2000)) - 1000);
            default: return $urandom;
        endcase
    endfunction

    function automatic int rand_twiddle();
        case ($urandom_range(0, 7))
            0:       return TW_ONE;
            1:       return -TW_ONE;
            default: return int'($urandom_range(0, 2 * TW_ONE)) - TW_ONE;
        endcase
    endfunction

    task automatic push_word(input logic cmd, input int k,
                             input logic signed [SAMPLE_WIDTH-1:0] re,
                             input logic signed [SAMPLE_WIDTH-1:0] im,
                             input int tr, input int ti);
        t_bin_word w;
        w.cmd      = cmd;
        w.index    = k[INDEX_WIDTH-1:0];
        w.value_re = re;
        w.value_im = im;
        w.rot_re   = tr[TWIDDLE_WIDTH-1:0];
        w.rot_im   = ti[TWIDDLE_WIDTH-1:0];
        pending_words.push_back(w);
        if (cmd == CMD_WRITE && k <= MAX_HALF_LENGTH)
            bin_written[k] = 1'b1;
    endtask

    task automatic write_bin(input int k, input logic signed [SAMPLE_WIDTH-1:0] re,
                             input logic signed [SAMPLE_WIDTH-1:0] im);
        push_word(CMD_WRITE, k, re, im, rand_twiddle(), rand_twiddle());
    endtask

    task automatic ensure_bin(input int k);
        if (!bin_written[k])
            write_bin(k, rand_sample(), rand_sample());
    endtask

    // request bin k, writing first any entry it reads that was never written
    task automatic request_bin(input int k, input int tr, input int ti);
        if (gen_direction == DIR_FORWARD && k <= gen_n) begin
            if (k == 0 || k == gen_n) begin
                ensure_bin(0);
            end else begin
                ensure_bin(k);
                ensure_bin(gen_n - k);
            end
        end else if (gen_direction == DIR_INVERSE && k < gen_n) begin
            ensure_bin(k);
            ensure_bin(gen_n - k);
        end
        push_word(CMD_REQUEST, k, rand_sample(), rand_sample(), tr, ti);
    endtask

    // true twiddle for k most of the time, otherwise a random q1.16 value from -1 to 1
    task automatic choose_twiddle(input int k, output int tr, output int ti);
        real ang;
        if ($urandom_range(0, 9) < 7) begin
            ang = PI * k / gen_n;
            tr  = int'($cos(ang) * TW_ONE);
            ti  = -int'($sin(ang) * TW_ONE);
        end else begin
            tr = rand_twiddle();
            ti = rand_twiddle();
        end
    endtask

    task automatic wait_idle();
        while (pending_words.size() != 0 || expected_bins.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // write both registers and one undecoded index while the core is idle
    task automatic set_config(input logic dir, input logic [CFG_DATA_WIDTH-1:0] half);
        t_reg_word w;
        wait_idle();
        w.index   = REG_DIRECTION;
        w.data    = CFG_DATA_WIDTH'($urandom);
        w.data[0] = dir;
        pending_regs.push_back(w);
        w.index = REG_HALF_LENGTH;
        w.data  = half;
        pending_regs.push_back(w);
        w.index = ($urandom_range(0, 1) == 0) ? REG_SPARE_A : REG_SPARE_B;
        w.data  = CFG_DATA_WIDTH'($urandom);
        pending_regs.push_back(w);
        while (pending_regs.size() != 0)
            @(posedge i_clk);
        @(posedge i_clk);
        gen_direction = dir;
        gen_n         = effective_n(half);
    endtask

    initial begin : stimulus
        int                        fixed_half [0:7];
        int                        counted, pick, k, tr, ti, lo;
        logic                      dir;
        logic [CFG_DATA_WIDTH-1:0] half;

        fixed_half = '{1, 1, 0, 1024, 2047, 2, 3, 1025};
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);

        // directed, reset settings: forward with the largest half length
        write_bin(0, SAMPLE_MAX, SAMPLE_MAX);
        request_bin(0, TW_ONE, 0);
        request_bin(MAX_HALF_LENGTH, -TW_ONE, 0);
        write_bin(0, SAMPLE_MIN, SAMPLE_MAX);
        request_bin(MAX_HALF_LENGTH, 0, 0);
        request_bin(0, 0, 0);
        write_bin(1, SAMPLE_MAX, SAMPLE_MIN);
        write_bin(MAX_HALF_LENGTH - 1, SAMPLE_MIN, SAMPLE_MAX);
        request_bin(1, TW_ONE, -TW_ONE);
        request_bin(MAX_HALF_LENGTH - 1, -TW_ONE, TW_ONE);
        write_bin(MAX_HALF_LENGTH / 2, -1, 1);
        request_bin(MAX_HALF_LENGTH / 2, 0, -TW_ONE);
        request_bin(MAX_HALF_LENGTH + 1, TW_ONE, TW_ONE);
        request_bin(2047, -TW_ONE, -TW_ONE);
        write_bin(MAX_HALF_LENGTH + 1, SAMPLE_MAX, SAMPLE_MAX);
        write_bin(2047, SAMPLE_MIN, SAMPLE_MIN);

        // directed, inverse: dc, edges and the first index out of range
        set_config(DIR_INVERSE, CFG_DATA_WIDTH'(MAX_HALF_LENGTH));
        write_bin(MAX_HALF_LENGTH, SAMPLE_MAX, SAMPLE_MIN);
        request_bin(0, 0, 0);
        request_bin(1, TW_ONE, TW_ONE);
        request_bin(MAX_HALF_LENGTH - 1, -TW_ONE, -TW_ONE);
        request_bin(MAX_HALF_LENGTH, 0, 0);

        // random phases, each under its own setting
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            dir = (p % 2 == 0) ? DIR_FORWARD : DIR_INVERSE;
            if (p < 8)
                half = CFG_DATA_WIDTH'(fixed_half[p]);
            else if ($urandom_range(0, 9) == 0)
                half = CFG_DATA_WIDTH'(MAX_HALF_LENGTH);
            else
                half = CFG_DATA_WIDTH'($urandom_range(2, 40));
            set_config(dir, half);
            counted = 0;
            while (counted < WORDS_PER_PHASE) begin
                pick = $urandom_range(0, 99);
                if (pick < 60) begin
                    // request in range
                    k = (gen_direction == DIR_FORWARD) ? $urandom_range(0, gen_n)
                                                       : $urandom_range(0, gen_n - 1);
                    choose_twiddle(k, tr, ti);
                    request_bin(k, tr, ti);
                    counted++;
                end else if (pick < 70) begin
                    // dc, nyquist and the outermost bins
                    if (gen_direction == DIR_FORWARD) begin
                        case ($urandom_range(0, 3))
                            0:       k = 0;
                            1:       k = gen_n;
                            2:       k = 1;
                            default: k = gen_n - 1;
                        endcase
                    end else begin
                        k = ($urandom_range(0, 1) == 0) ? 0 : gen_n - 1;
                    end
                    choose_twiddle(k, tr, ti);
                    request_bin(k, tr, ti);
                    counted++;
                end else if (pick < 82) begin
                    // overwrite a bin
                    k = ($urandom_range(0, 4) == 0) ? $urandom_range(0, MAX_HALF_LENGTH)
                                                    : $urandom_range(0, gen_n);
                    write_bin(k, rand_sample(), rand_sample());
                    counted++;
                end else if (pick < 94) begin
                    // request beyond the range of the mode
                    lo = (gen_direction == DIR_FORWARD) ? gen_n + 1 : gen_n;
                    k  = $urandom_range(lo, 2047);
                    choose_twiddle(k, tr, ti);
                    request_bin(k, tr, ti);
                    counted++;
                end else begin
                    // write past the store, dropped by the core
                    write_bin($urandom_range(MAX_HALF_LENGTH + 1, 2047),
                              rand_sample(), rand_sample());
                end
            end
        end

        wait_idle();
        if (fail_count == 0)
            $display("PASS real_fft_split_untwiddle_core");
        else
            $display("FAIL real_fft_split_untwiddle_core");
        $finish;
    end

endmodule

@@ real_fft_split_untwiddle_core.f @@
src/rfsu_pkg.sv
src/real_fft_split_untwiddle_core.sv
sim/tb_top.sv
